// ===== src/cc_pkg.sv =====
// ----------------------------------------------------------------------------
// cc_pkg: shared types and constants for the coordinate conversion core
// Arctangent table, gain and angle limits used by the front and back stages.
// ----------------------------------------------------------------------------
package cc_pkg;

  localparam int TABLE_LEN = 24;
  localparam int ZW        = 28;   // angle accumulator, 2^-16 degree
  localparam int DEG180    = 180;

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(DEG180 * 65536);
  localparam logic signed [16:0]   A_HALF = 17'(DEG180 * 128);
  localparam logic signed [16:0]   A_QUARTER = 17'(DEG180 * 64);
  localparam logic [23:0]          GAIN_Q24 = 24'd10188014;

  typedef enum logic {
    MODE_VECTOR = 1'b0,
    MODE_ROTATE = 1'b1
  } mode_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        0:  v = ZW'(2949120);
        1:  v = ZW'(1740967);
        2:  v = ZW'(919879);
        3:  v = ZW'(466945);
        4:  v = ZW'(234379);
        5:  v = ZW'(117304);
        6:  v = ZW'(58666);
        7:  v = ZW'(29335);
        8:  v = ZW'(14668);
        9:  v = ZW'(7334);
        10: v = ZW'(3667);
        11: v = ZW'(1833);
        12: v = ZW'(917);
        13: v = ZW'(458);
        14: v = ZW'(229);
        15: v = ZW'(115);
        16: v = ZW'(57);
        17: v = ZW'(29);
        18: v = ZW'(14);
        19: v = ZW'(7);
        20: v = ZW'(4);
        21: v = ZW'(2);
        22: v = ZW'(1);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== src/cc_front.sv =====
// ----------------------------------------------------------------------------
// cc_front: input classification and start vector
// Accepts requests, reduces the angle, picks the start quadrant and zero case.
// ----------------------------------------------------------------------------
module cc_front
  import cc_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int XW = DATA_WIDTH + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic signed [15:0]   a,
  input  logic signed [15:0]   b,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_mode,
  output logic                 q_zero,
  output logic signed [XW-1:0] q_x,
  output logic signed [XW-1:0] q_y,
  output logic signed [ZW-1:0] q_z
);

  logic signed [XW-1:0] ai, bi, x_next, y_next;
  logic signed [ZW-1:0] z_next;
  logic signed [16:0]   bb;
  logic                 zero_next;

  function automatic logic signed [XW-1:0] to_int(input logic signed [15:0] v);
    logic signed [XW+15:0] t;
    begin
      t = {{XW{v[15]}}, v};
      if (DATA_WIDTH >= 16) t = t <<< (DATA_WIDTH - 16);
      else                  t = t >>> (16 - DATA_WIDTH);
      return t[XW-1:0];
    end
  endfunction

  assign in_ready = !q_valid || q_ready;

  always_comb begin
    ai = to_int(a);
    bi = to_int(b);
    zero_next = 1'b0;
    bb = 17'(b);
    x_next = ai;
    y_next = bi;
    z_next = '0;
    if (mode == MODE_VECTOR) begin
      zero_next = (a == 0) && (b == 0);
      if (a < 0) begin
        x_next = -ai;
        y_next = -bi;
        z_next = (b >= 0) ? Z_HALF : -Z_HALF;
      end
    end else begin
      if (bb > A_HALF) bb = bb - (A_HALF <<< 1);
      else if (bb < -A_HALF) bb = bb + (A_HALF <<< 1);
      x_next = ai;
      y_next = '0;
      if (bb > A_QUARTER) begin
        x_next = '0; y_next = ai; bb = bb - A_QUARTER;
      end else if (bb < -A_QUARTER) begin
        x_next = '0; y_next = -ai; bb = bb + A_QUARTER;
      end
      z_next = ZW'(bb) <<< 9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_mode <= mode;
      q_zero <= zero_next;
      q_x    <= x_next;
      q_y    <= y_next;
      q_z    <= z_next;
    end
  end

endmodule

// ===== src/cc_back.sv =====
// ----------------------------------------------------------------------------
// cc_back: pipelined CORDIC stages, gain, rounding and saturation
// One micro-rotation per stage, then gain multiply and output register.
// ----------------------------------------------------------------------------
module cc_back
  import cc_pkg::*;
#(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16,
  parameter int XW = DATA_WIDTH + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic                 s_mode,
  input  logic                 s_zero,
  input  logic signed [XW-1:0] s_x,
  input  logic signed [XW-1:0] s_y,
  input  logic signed [ZW-1:0] s_z,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic                 m_mode,
  output logic signed [16:0]   m_first,
  output logic signed [15:0]   m_second
);

  localparam int N   = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int SH  = 24 + DATA_WIDTH - 16;
  localparam int PW  = XW + 25;

  logic                 vld  [N+2];
  logic                 md   [N+2];
  logic                 zr   [N+2];
  logic signed [XW-1:0] px   [N+1];
  logic signed [XW-1:0] py   [N+1];
  logic signed [ZW-1:0] pz   [N+1];
  logic signed [PW-1:0] gx, gy;
  logic signed [ZW-1:0] gz;
  logic                 adv;

  // whole pipe advances together; output register frees it
  assign adv     = !m_valid || m_ready;
  assign s_ready = adv;

  assign vld[0] = s_valid;
  assign md[0]  = s_mode;
  assign zr[0]  = s_zero;
  assign px[0]  = s_x;
  assign py[0]  = s_y;
  assign pz[0]  = s_z;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 dir;
    logic signed [XW-1:0] xs, ys;
    assign xs  = px[i] >>> i;
    assign ys  = py[i] >>> i;
    assign dir = (md[i] == MODE_VECTOR) ? (py[i] >= 0) : (pz[i] < 0);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        md[i+1] <= md[i];
        zr[i+1] <= zr[i];
        if (dir) begin
          px[i+1] <= px[i] + ys;
          py[i+1] <= py[i] - xs;
          pz[i+1] <= pz[i] + atan_entry(i);
        end else begin
          px[i+1] <= px[i] - ys;
          py[i+1] <= py[i] + xs;
          pz[i+1] <= pz[i] - atan_entry(i);
        end
      end
    end
  end

  // gain multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[N+1] <= 1'b0;
    end else if (adv) begin
      vld[N+1] <= vld[N];
    end
    if (adv) begin
      md[N+1] <= md[N];
      zr[N+1] <= zr[N];
      gx <= PW'(px[N]) * $signed({1'b0, GAIN_Q24});
      gy <= PW'(py[N]) * $signed({1'b0, GAIN_Q24});
      gz <= pz[N];
    end
  end

  logic signed [PW-1:0] rx, ry;
  logic signed [ZW-1:0] rz;
  logic signed [16:0]   f_next;
  logic signed [15:0]   s_next;

  always_comb begin
    rx = (gx + (PW'(1) <<< (SH - 1))) >>> SH;
    ry = (gy + (PW'(1) <<< (SH - 1))) >>> SH;
    rz = (gz + ZW'(256)) >>> 9;
    if (zr[N+1]) begin
      f_next = '0;
      s_next = '0;
    end else if (md[N+1] == MODE_VECTOR) begin
      if (rx < 0)                 f_next = '0;
      else if (rx > PW'(46341))   f_next = 17'sd46341;
      else                        f_next = rx[16:0];
      if (rz > ZW'(A_HALF))       s_next = 16'(A_HALF);
      else if (rz < -ZW'(A_HALF)) s_next = 16'(-A_HALF);
      else                        s_next = rz[15:0];
    end else begin
      if (rx > PW'(32767))        f_next = 17'sd32767;
      else if (rx < -PW'(32768))  f_next = -17'sd32768;
      else                        f_next = rx[16:0];
      if (ry > PW'(32767))        s_next = 16'sd32767;
      else if (ry < -PW'(32768))  s_next = -16'sd32768;
      else                        s_next = ry[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= vld[N+1];
    end
    if (adv) begin
      m_mode   <= md[N+1];
      m_first  <= f_next;
      m_second <= s_next;
    end
  end

endmodule

// ===== src/coordinate_conversion_core.sv =====
// ----------------------------------------------------------------------------
// coordinate_conversion_core: CORDIC rectangular/polar converter
// Front stage classifies requests, a register queues them, back pipe rotates.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits                            | tuser
//  s_axis   | in  | [15:0] first_operand [31:16] second   | mode
//  m_axis   | out | [16:0] first_result [32:17] second    | mode_echo
//
// One request per cycle sustained while m_axis accepts. Registers: front
// register, one CORDIC stage per iteration up to TABLE_LEN, gain multiply,
// output register. Reset clears all valid bits. A stall at m_axis freezes
// the whole pipe and drops s_axis_tready once the front register is full.
module coordinate_conversion_core
  import cc_pkg::*;
#(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // first_operand, second_operand
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // first_result, second_result, zero pad
  output logic        m_axis_tuser    // mode_echo
);

  localparam int XW = DATA_WIDTH + 4;

  logic                 q_valid, q_ready, q_mode, q_zero;
  logic signed [XW-1:0] q_x, q_y;
  logic signed [ZW-1:0] q_z;
  logic signed [16:0]   first_result;
  logic signed [15:0]   second_result;

  cc_front #(.DATA_WIDTH(DATA_WIDTH), .XW(XW)) u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .mode     (s_axis_tuser),
    .a        (s_axis_tdata[15:0]),
    .b        (s_axis_tdata[31:16]),
    .q_valid, .q_ready, .q_mode, .q_zero, .q_x, .q_y, .q_z
  );

  cc_back #(.ITERATIONS(ITERATIONS), .DATA_WIDTH(DATA_WIDTH), .XW(XW)) u_back (
    .clk, .rst,
    .s_valid  (q_valid),
    .s_ready  (q_ready),
    .s_mode   (q_mode),
    .s_zero   (q_zero),
    .s_x      (q_x),
    .s_y      (q_y),
    .s_z      (q_z),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_mode   (m_axis_tuser),
    .m_first  (first_result),
    .m_second (second_result)
  );

  assign m_axis_tdata = {7'b0, second_result, first_result};

endmodule

// ===== tb/sv/coordinate_conversion_checker.sv =====
// ----------------------------------------------------------------------------
// coordinate_conversion_checker: result predictor and scoreboard
// Watches both stream channels, computes the CORDIC result of every accepted
// request and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module coordinate_conversion_checker
  import cc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // first_operand, second_operand
  input  logic        s_axis_tuser,   // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // first_result, second_result, zero pad
  input  logic        m_axis_tuser,   // mode_echo
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NITER = 16;

  typedef struct packed {
    mode_t              mode;
    logic signed [16:0] first;
    logic signed [15:0] second;
  } conv_result_t;

  conv_result_t expected_q[$];

  localparam longint ATAN_TAB [24] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0};

  function automatic longint scale_gain(longint v);
    return (v * 64'sd10188014 + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic conv_result_t convert(logic mode, logic signed [15:0] a_in,
                                           logic signed [15:0] b_in);
    conv_result_t res;
    longint a, b, x, y, z, xs, ys;
    a = a_in;
    b = b_in;
    res.mode = mode_t'(mode);
    if (mode == MODE_VECTOR) begin
      if (a == 0 && b == 0) begin
        res.first = '0;
        res.second = '0;
      end else begin
        x = a;
        y = b;
        z = 0;
        if (a < 0) begin
          x = -x;
          y = -y;
          z = (b >= 0) ? 180 * 65536 : -180 * 65536;
        end
        for (int i = 0; i < NITER; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
          end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
          end
        end
        res.first = 17'(clip(scale_gain(x), 0, 46341));
        res.second = 16'(clip((z + 256) >>> 9, -23040, 23040));
      end
    end else begin
      x = a;
      y = 0;
      if (b > 23040) b -= 46080;
      else if (b < -23040) b += 46080;
      if (b > 11520) begin
        x = 0; y = a; b -= 11520;
      end else if (b < -11520) begin
        x = 0; y = -a; b += 11520;
      end
      z = b * 512;
      for (int i = 0; i < NITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= ATAN_TAB[i];
        end else begin
          x += ys; y -= xs; z += ATAN_TAB[i];
        end
      end
      res.first = 17'(clip(scale_gain(x), -32768, 32767));
      res.second = 16'(clip(scale_gain(y), -32768, 32767));
    end
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    conv_result_t want, got;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(convert(s_axis_tuser, s_axis_tdata[15:0],
                                     s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.mode = mode_t'(m_axis_tuser);
        got.first = m_axis_tdata[16:0];
        got.second = m_axis_tdata[32:17];
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got) begin
            if (errors < 10)
              $display("mismatch: exp mode=%0d r1=%0d r2=%0d got mode=%0d r1=%0d r2=%0d",
                       want.mode, want.first, want.second,
                       got.mode, got.first, got.second);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_coordinate_conversion_core.sv =====
// ----------------------------------------------------------------------------
// tb_coordinate_conversion_core: stimulus and verdict for the CORDIC core
// Drives directed corner requests and random requests in both modes with
// random idling on either side, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_coordinate_conversion_core
  import cc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // first_operand, second_operand
  logic        s_axis_tuser = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // first_result, second_result, zero pad
  logic        m_axis_tuser;        // mode_echo
  int          errors;
  int          pending;
  int          send_idle_pct = 6;
  int          recv_idle_pct = 48;
  int          hold_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  coordinate_conversion_core dut (.*);

  coordinate_conversion_checker scoreboard (.*);

  // Receiver: random stalls, plus a counted long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic mode, logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(3))
      0: return 16'($urandom_range(2047)) - 16'd1024;
      1: return 16'($urandom_range(46080)) - 16'd23040;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_request(1'($urandom), rand_operand(), rand_operand());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #200000;
    $display("FAIL coordinate_conversion_core");
    $finish;
  end

  initial begin
    logic [15:0] corners [7];
    corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd23040,
                16'(-23040)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(MODE_VECTOR, 16'h0000, 16'h0000);
    send_request(MODE_VECTOR, 16'hFF00, 16'h0000);
    send_request(MODE_VECTOR, 16'hFF00, 16'hFFFF);
    send_request(MODE_VECTOR, 16'h8000, 16'h8000);
    send_request(MODE_VECTOR, 16'h7FFF, 16'h7FFF);
    send_request(MODE_VECTOR, 16'h0000, 16'h8000);
    send_request(MODE_ROTATE, 16'h7FFF, 16'h7FFF);
    send_request(MODE_ROTATE, 16'h7FFF, 16'h8000);
    send_request(MODE_ROTATE, 16'h8000, 16'd5760);
    send_request(MODE_ROTATE, 16'h7FFF, 16'd11521);
    send_request(MODE_ROTATE, 16'h7FFF, 16'(-11521));
    send_request(MODE_ROTATE, 16'h0100, 16'd23041);
    send_request(MODE_ROTATE, 16'h0100, 16'(-23041));
    for (int i = 0; i < 7; i++)
      send_request(1'(i), corners[i], corners[6 - i]);
    random_phase(380);
    // Long hold-off at the output while requests keep coming.
    hold_cycles = 200;
    random_phase(60);
    drain();
    send_idle_pct = 48;
    recv_idle_pct = 6;
    random_phase(350);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(350);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS coordinate_conversion_core");
    end else begin
      $display("FAIL coordinate_conversion_core");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/cc_pkg.sv
src/cc_front.sv
src/cc_back.sv
src/coordinate_conversion_core.sv
tb/sv/coordinate_conversion_checker.sv
tb/sv/tb_coordinate_conversion_core.sv
